### hw/rtl/assert_macros.svh
// assertion macros shared by the mailbox rtl
// no dependencies; included by files that carry concurrent checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check a property on every rising clock edge outside reset
`define MRB_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// same check with an implication spelled out as two parts
`define MRB_ASSERT_IMP(lbl, clk, rstn, pre, post, msg) \
  `MRB_ASSERT(lbl, clk, rstn, (pre) |-> (post), msg)

`endif

### hw/rtl/mrb_pkg.sv
// shared types and constants of the mailbox ring buffer
// no dependencies; imported by mrb_ctrl, mrb_dp and the top level
package mrb_pkg;

  localparam int unsigned DefDepth = 16;
  localparam int unsigned MsgBits  = 32;
  localparam int unsigned CapW     = 5;
  localparam int unsigned CntW     = 5;
  localparam int unsigned ActW     = 2;
  localparam int unsigned StatW    = 2;

  localparam logic [CapW-1:0] CapReset = 5'd16;

  typedef enum logic [ActW-1:0] {
    ACT_GET   = 2'd0,
    ACT_POST  = 2'd1,
    ACT_FLUSH = 2'd2,
    ACT_NOP   = 2'd3
  } action_e;

  typedef enum logic [StatW-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic exec;
    logic load_rdata;
  } mrb_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic need_read;
  } mrb_stat_t;

endpackage

### hw/rtl/mrb_ram.sv
// generic single write port ram with registered read
// no dependencies
module mrb_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/mrb_ctrl.sv
// sequencing state machine of the mailbox
// depends on mrb_pkg and assert_macros.svh
`include "assert_macros.svh"

module mrb_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  output logic               done_o,
  output mrb_pkg::mrb_cmd_t  cmd_o,
  input  mrb_pkg::mrb_stat_t stat_i
);

  import mrb_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EXEC = 4'b0010,
    S_RD   = 4'b0100,
    S_RESP = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign busy   = (state_q == S_EXEC) || (state_q == S_RD);
  assign accept = start && !busy;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) state_d = S_EXEC;
      end
      S_EXEC: begin
        state_d = stat_i.need_read ? S_RD : S_RESP;
      end
      S_RD: begin
        state_d = S_RESP;
      end
      S_RESP: begin
        state_d = accept ? S_EXEC : S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign cmd_o.capture    = accept;
  assign cmd_o.exec       = (state_q == S_EXEC);
  assign cmd_o.load_rdata = (state_q == S_RD);
  assign done_o           = (state_q == S_RESP);

  `MRB_ASSERT_IMP(a_accept_exec, clk_i, rst_ni, accept, ##1 (state_q == S_EXEC),
                  "accepted transaction did not start executing")
  `MRB_ASSERT_IMP(a_exec_resp, clk_i, rst_ni, (state_q == S_EXEC) && !stat_i.need_read,
                  ##1 done_o, "transaction without read missed its response cycle")
  `MRB_ASSERT_IMP(a_rd_resp, clk_i, rst_ni, state_q == S_RD, ##1 done_o,
                  "read wait not followed by response")

endmodule

### hw/rtl/mrb_dp.sv
// mailbox datapath: indices, count, capacity, message ram and result registers
// depends on mrb_pkg, mrb_ram and assert_macros.svh
`include "assert_macros.svh"

module mrb_dp #(
  parameter int unsigned DEPTH = mrb_pkg::DefDepth
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  mrb_pkg::mrb_cmd_t            cmd_i,
  output mrb_pkg::mrb_stat_t           stat_o,
  input  logic                         cfg_we_i,
  input  logic [mrb_pkg::CapW-1:0]     cfg_wdata_i,
  input  logic [mrb_pkg::ActW-1:0]     action_i,
  input  logic [mrb_pkg::MsgBits-1:0]  message_i,
  input  logic                         to_front_i,
  input  logic                         waiter_present_i,
  output logic [mrb_pkg::StatW-1:0]    status_o,
  output logic [mrb_pkg::MsgBits-1:0]  message_out_o,
  output logic                         handed_to_waiter_o,
  output logic [mrb_pkg::CntW-1:0]     fill_count_o
);

  import mrb_pkg::*;

  localparam int unsigned IdxW = $clog2(DEPTH);
  localparam int unsigned CmpW = ((IdxW > CapW) ? IdxW : CapW) + 1;

  // captured transaction
  action_e              act_q;
  logic [MsgBits-1:0]   msg_q;
  logic                 front_q;
  logic                 waiter_q;

  // mailbox state
  logic [CapW-1:0]      cap_q;
  logic [IdxW-1:0]      rd_q, rd_d;
  logic [IdxW-1:0]      wr_q, wr_d;
  logic [CntW-1:0]      cnt_q, cnt_d;

  // result registers
  status_e              status_q, status_d;
  logic [MsgBits-1:0]   mout_q, mout_d;
  logic                 handed_q, handed_d;
  logic [CntW-1:0]      fill_q;

  logic [CmpW-1:0]      cap_raw, depth_c, cap_eff, cap_m1;
  logic [CmpW-1:0]      rd_ext, wr_ext, rd_inc, wr_inc, cnt_ext;
  logic                 ram_we;
  logic [IdxW-1:0]      ram_waddr;
  logic                 ram_re;
  logic [MsgBits-1:0]   ram_rdata;

  // capacity clamped to 1..DEPTH
  assign cap_raw = CmpW'(cap_q);
  assign depth_c = CmpW'(DEPTH);
  assign cap_eff = (cap_q == '0) ? CmpW'(1) : ((cap_raw > depth_c) ? depth_c : cap_raw);
  assign cap_m1  = cap_eff - CmpW'(1);

  assign rd_ext  = CmpW'(rd_q);
  assign wr_ext  = CmpW'(wr_q);
  assign rd_inc  = rd_ext + CmpW'(1);
  assign wr_inc  = wr_ext + CmpW'(1);
  assign cnt_ext = CmpW'(cnt_q);

  assign stat_o.need_read = (act_q == ACT_GET) && (cnt_q != '0);

  always_comb begin
    rd_d      = rd_q;
    wr_d      = wr_q;
    cnt_d     = cnt_q;
    status_d  = ST_OK;
    mout_d    = '0;
    handed_d  = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = wr_q;
    ram_re    = 1'b0;
    unique case (act_q)
      ACT_GET: begin
        if (cnt_q != '0) begin
          cnt_d  = cnt_q - CntW'(1);
          ram_re = 1'b1;
          rd_d   = (rd_inc >= cap_eff) ? '0 : rd_inc[IdxW-1:0];
        end else begin
          status_d = ST_EMPTY;
        end
      end
      ACT_POST: begin
        if (waiter_q) begin
          mout_d   = msg_q;
          handed_d = 1'b1;
        end else if (cnt_ext >= cap_eff) begin
          status_d = ST_FULL;
        end else begin
          ram_we = 1'b1;
          if (front_q) begin
            // step the head back, wrapping to the last slot in use
            rd_d = ((rd_q == '0) || (rd_ext > cap_eff)) ? cap_m1[IdxW-1:0]
                                                        : rd_q - IdxW'(1);
            ram_waddr = rd_d;
          end else begin
            ram_waddr = wr_q;
            wr_d      = (wr_inc >= cap_eff) ? '0 : wr_inc[IdxW-1:0];
          end
          cnt_d = cnt_q + CntW'(1);
        end
      end
      ACT_FLUSH: begin
        if (!waiter_q) begin
          rd_d  = '0;
          wr_d  = '0;
          cnt_d = '0;
        end
      end
      ACT_NOP: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      msg_q    <= message_i;
      front_q  <= to_front_i;
      waiter_q <= waiter_present_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q    <= ACT_NOP;
      cap_q    <= CapReset;
      rd_q     <= '0;
      wr_q     <= '0;
      cnt_q    <= '0;
      status_q <= ST_OK;
      mout_q   <= '0;
      handed_q <= 1'b0;
      fill_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      if (cmd_i.capture) begin
        act_q <= action_e'(action_i);
      end
      if (cmd_i.exec) begin
        rd_q     <= rd_d;
        wr_q     <= wr_d;
        cnt_q    <= cnt_d;
        status_q <= status_d;
        mout_q   <= mout_d;
        handed_q <= handed_d;
        fill_q   <= cnt_d;
      end else if (cmd_i.load_rdata) begin
        mout_q <= ram_rdata;
      end
    end
  end

  mrb_ram #(
    .WIDTH (MsgBits),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we && cmd_i.exec),
    .waddr_i (ram_waddr),
    .wdata_i (msg_q),
    .re_i    (ram_re && cmd_i.exec),
    .raddr_i (rd_q),
    .rdata_o (ram_rdata)
  );

  assign status_o           = status_q;
  assign message_out_o      = mout_q;
  assign handed_to_waiter_o = handed_q;
  assign fill_count_o       = fill_q;

  `MRB_ASSERT(a_idx_range, clk_i, rst_ni, (rd_ext < depth_c) && (wr_ext < depth_c),
              "ring index outside the built depth")
  `MRB_ASSERT_IMP(a_handed_ok, clk_i, rst_ni, handed_q, status_q == ST_OK,
                  "handed message reported with error status")
  `MRB_ASSERT_IMP(a_empty_fill, clk_i, rst_ni, status_q == ST_EMPTY, fill_q == '0,
                  "empty status with messages stored")

endmodule

### hw/rtl/mailbox_ring_buffer_with_front_post.sv
// top level of the mailbox ring buffer with front post
// depends on mrb_pkg, mrb_ctrl, mrb_dp (and through it mrb_ram)
//
// Message mailbox kept as a ring of DEPTH words whose slots in use are set by
// the capacity register (0 acts as 1, values above DEPTH act as DEPTH). A
// transaction is taken when start is high and busy is low; its single result
// sits on the result ports for exactly one cycle with done_o high, and the
// receiver cannot stall it, so it must sample whenever done_o is set. A get,
// when a message is stored, passes through the execute, ram read wait and
// response states, the read wait being for the registered read port of the
// message ram. Every other transaction (post, flush, empty get, unused code)
// goes from execute straight to response. The next transaction can be taken
// in the same cycle as a response, but not while one executes or waits on
// the ram. Posts with a waiting task hand the word straight back on
// message_out_o with handed_to_waiter_o set and store nothing. Capacity is
// written through cfg_we_i / cfg_wdata_i and must only change while no
// transaction is outstanding. There is no clearing pass after reset.
module mailbox_ring_buffer_with_front_post #(
  parameter int unsigned DEPTH = mrb_pkg::DefDepth
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // capacity register write
  input  logic                         cfg_we_i,
  input  logic [mrb_pkg::CapW-1:0]     cfg_wdata_i,
  // request side
  input  logic                         start,
  output logic                         busy,
  input  logic [mrb_pkg::ActW-1:0]     action_i,
  input  logic [mrb_pkg::MsgBits-1:0]  message_i,
  input  logic                         to_front_i,
  input  logic                         waiter_present_i,
  // result side, one cycle strobe
  output logic                         done_o,
  output logic [mrb_pkg::StatW-1:0]    status_o,
  output logic [mrb_pkg::MsgBits-1:0]  message_out_o,
  output logic                         handed_to_waiter_o,
  output logic [mrb_pkg::CntW-1:0]     fill_count_o
);

  import mrb_pkg::*;

  // command and status between sequencer and datapath
  mrb_cmd_t  cmd;
  mrb_stat_t stat;

  // sequencer: idle, execute, ram read wait, response
  mrb_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .done_o (done_o),
    .cmd_o  (cmd),
    .stat_i (stat)
  );

  // datapath: ring indices, count, capacity, message ram, result registers
  mrb_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .stat_o             (stat),
    .cfg_we_i           (cfg_we_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .action_i           (action_i),
    .message_i          (message_i),
    .to_front_i         (to_front_i),
    .waiter_present_i   (waiter_present_i),
    .status_o           (status_o),
    .message_out_o      (message_out_o),
    .handed_to_waiter_o (handed_to_waiter_o),
    .fill_count_o       (fill_count_o)
  );

endmodule
